FILE: design/exfat_entry_set_parser_defines.svh
// assertion macros shared by the parser modules
// each macro expects clk and rst_n in scope
`ifndef EXFAT_ENTRY_SET_PARSER_DEFINES_SVH
`define EXFAT_ENTRY_SET_PARSER_DEFINES_SVH

// condition must hold at every edge out of reset
`define ESP_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ESP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/exfat_esp_pkg.sv
// ----------------------------------------------------------------------------
// exfat_esp_pkg
// types, entry type codes and result arithmetic for the entry set parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package exfat_esp_pkg;

    // entry type codes
    localparam logic [7:0] TYPE_END         = 8'h00;
    localparam logic [7:0] TYPE_FILE_LIVE   = 8'h85;
    localparam logic [7:0] TYPE_FILE_DEL    = 8'h05;
    localparam logic [7:0] TYPE_STREAM_LIVE = 8'hC0;
    localparam logic [7:0] TYPE_STREAM_DEL  = 8'h40;
    localparam logic [7:0] TYPE_NAME_LIVE   = 8'hC1;
    localparam logic [7:0] TYPE_NAME_DEL    = 8'h41;
    localparam logic [7:0] TYPE_BITMAP      = 8'h81;

    localparam int unsigned ATTR_DIR_BIT     = 4;   // attribute 0x10
    localparam int unsigned FLAG_CONTIG_BIT  = 1;   // stream flag 0x02
    localparam int unsigned BITMAP_LIMIT_LOG = 27;  // 128 MiB

    // result kinds
    localparam logic [1:0] KIND_DELETED = 2'd0;
    localparam logic [1:0] KIND_SUBDIR  = 2'd1;
    localparam logic [1:0] KIND_BITMAP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_VOLUME_CLUSTERS = 2'd0;
    localparam logic [1:0] REG_CLUSTER_SHIFT   = 2'd1;
    localparam logic [1:0] REG_REPORT_BITMAP   = 2'd2;

    localparam logic [31:0] VOLUME_CLUSTERS_RST = 32'd0;
    localparam logic [4:0]  CLUSTER_SHIFT_RST   = 5'd12;
    localparam logic        REPORT_BITMAP_RST   = 1'b1;

    localparam int unsigned MAX_NAME_ENTRIES_DEF = 18;
    localparam int unsigned NAMES_W              = 5;

    localparam int unsigned IN_TDATA_W   = 128;
    localparam int unsigned OUT_TDATA_W  = 136;
    localparam int unsigned OUT_TUSER_W  = 2;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned CFG_DATA_W   = 32;

    // result queue
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_LVL_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  entry_type;
        logic [7:0]  byte_one;
        logic [15:0] attributes;
        logic [31:0] entry_first_cluster;
        logic [63:0] entry_data_length;
        logic        last_in_dir;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        start_cluster;
        logic [63:0]        byte_length;
        logic               contiguous;
        logic               is_dir;
        logic [NAMES_W-1:0] names_found;
        logic               cluster_ok;
        logic [31:0]        clusters_needed;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic [31:0] volume_clusters;
        logic [4:0]  cluster_shift;
        logic        report_bitmap;
    } cfg_t;

    // length rounded up to whole clusters, low 32 bits
    function automatic logic [31:0] clusters_for(input logic [63:0] len,
                                                 input logic [4:0]  sh);
        logic [63:0] mask;
        logic [63:0] whole;
        mask  = (64'd1 << sh) - 64'd1;
        whole = (len >> sh) + {63'd0, |(len & mask)};
        return whole[31:0];
    endfunction

    function automatic logic cluster_in_range(input logic [31:0] cl,
                                              input logic [31:0] vol);
        logic [32:0] lim;
        lim = {1'b0, vol} + 33'd2;
        return (cl >= 32'd2) && ({1'b0, cl} < lim);
    endfunction

endpackage

`default_nettype wire

FILE: design/exfat_esp_core.sv
// ----------------------------------------------------------------------------
// exfat_esp_core
// entry set tracking and result forming for one registered entry per cycle while adv is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "exfat_entry_set_parser_defines.svh"

module exfat_esp_core #(
    parameter int unsigned MAX_NAME_ENTRIES = exfat_esp_pkg::MAX_NAME_ENTRIES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire exfat_esp_pkg::item_t   item,
    input  wire exfat_esp_pkg::cfg_t    cfg,
    output logic [1:0]                  push_count,
    output exfat_esp_pkg::result_t      res_a,
    output exfat_esp_pkg::result_t      res_b
);
    import exfat_esp_pkg::*;

    localparam logic [NAMES_W-1:0] MaxNames = NAMES_W'(MAX_NAME_ENTRIES);

    logic               set_active_reg, set_active_next;
    logic               set_deleted_reg, set_deleted_next;
    logic [7:0]         slots_left_reg, slots_left_next;
    logic               stream_pending_reg, stream_pending_next;
    logic               stream_match_reg, stream_match_next;
    logic               set_is_dir_reg, set_is_dir_next;
    logic [31:0]        saved_cluster_reg, saved_cluster_next;
    logic [63:0]        saved_length_reg, saved_length_next;
    logic               saved_contig_reg, saved_contig_next;
    logic [NAMES_W-1:0] name_tally_reg, name_tally_next;
    logic               dir_ended_reg, dir_ended_next;
    logic               bitmap_stopped_reg, bitmap_stopped_next;

    logic               live;
    logic               is_end;
    logic               in_set;
    logic               closing;
    logic               open_set;
    logic               bm_hit;
    logic               set_hit;
    logic [7:0]         stream_exp;
    logic [7:0]         name_exp;
    logic               match_now;
    logic [31:0]        cl_now;
    logic [63:0]        len_now;
    logic               contig_now;
    logic [NAMES_W-1:0] tally_now;
    result_t            bm_res;
    result_t            set_res;

    always_comb
    begin
        live   = !dir_ended_reg;
        is_end = item.entry_type == TYPE_END;
        in_set = live && set_active_reg;

        bm_hit = live && !bitmap_stopped_reg && cfg.report_bitmap
              && item.entry_type == TYPE_BITMAP
              && item.entry_first_cluster >= 32'd2
              && item.entry_data_length != 64'd0
              && item.entry_data_length[63:BITMAP_LIMIT_LOG] == '0;

        stream_exp = set_deleted_reg ? TYPE_STREAM_DEL : TYPE_STREAM_LIVE;
        name_exp   = set_deleted_reg ? TYPE_NAME_DEL : TYPE_NAME_LIVE;

        // first secondary of the set is the stream entry
        match_now  = stream_pending_reg ? (item.entry_type == stream_exp) : stream_match_reg;
        cl_now     = stream_pending_reg ? item.entry_first_cluster : saved_cluster_reg;
        len_now    = stream_pending_reg ? item.entry_data_length : saved_length_reg;
        contig_now = stream_pending_reg ? item.byte_one[FLAG_CONTIG_BIT] : saved_contig_reg;

        tally_now = name_tally_reg;
        if (!stream_pending_reg && stream_match_reg && name_tally_reg < MaxNames
            && item.entry_type == name_exp)
        begin
            tally_now = name_tally_reg + NAMES_W'(1);
        end

        closing = in_set && slots_left_reg == 8'd1;
        set_hit = closing && match_now
               && (set_deleted_reg || (set_is_dir_reg && cl_now >= 32'd2));

        open_set = live && !set_active_reg && !is_end && item.byte_one != 8'd0
                && (item.entry_type == TYPE_FILE_LIVE || item.entry_type == TYPE_FILE_DEL);
    end

    always_comb
    begin
        bm_res.kind            = KIND_BITMAP;
        bm_res.start_cluster   = item.entry_first_cluster;
        bm_res.byte_length     = item.entry_data_length;
        bm_res.contiguous      = 1'b1;
        bm_res.is_dir          = 1'b0;
        bm_res.names_found     = '0;
        bm_res.cluster_ok      = cluster_in_range(item.entry_first_cluster,
                                                  cfg.volume_clusters);
        bm_res.clusters_needed = clusters_for(item.entry_data_length, cfg.cluster_shift);
        bm_res.last_result     = !set_hit;

        set_res.kind            = set_deleted_reg ? KIND_DELETED : KIND_SUBDIR;
        set_res.start_cluster   = cl_now;
        set_res.byte_length     = len_now;
        set_res.contiguous      = contig_now;
        set_res.is_dir          = set_is_dir_reg;
        set_res.names_found     = tally_now;
        set_res.cluster_ok      = cluster_in_range(cl_now, cfg.volume_clusters);
        set_res.clusters_needed = clusters_for(len_now, cfg.cluster_shift);
        set_res.last_result     = 1'b1;

        res_a      = bm_hit ? bm_res : set_res;
        res_b      = set_res;
        push_count = adv ? ({1'b0, bm_hit} + {1'b0, set_hit}) : 2'd0;
    end

    always_comb
    begin
        set_active_next     = set_active_reg;
        set_deleted_next    = set_deleted_reg;
        slots_left_next     = slots_left_reg;
        stream_pending_next = stream_pending_reg;
        stream_match_next   = stream_match_reg;
        set_is_dir_next     = set_is_dir_reg;
        saved_cluster_next  = saved_cluster_reg;
        saved_length_next   = saved_length_reg;
        saved_contig_next   = saved_contig_reg;
        name_tally_next     = name_tally_reg;
        dir_ended_next      = dir_ended_reg || (live && !set_active_reg && is_end);
        bitmap_stopped_next = bitmap_stopped_reg || (live && is_end);

        if (in_set)
        begin
            stream_pending_next = 1'b0;
            stream_match_next   = match_now;
            saved_cluster_next  = cl_now;
            saved_length_next   = len_now;
            saved_contig_next   = contig_now;
            name_tally_next     = tally_now;
            slots_left_next     = slots_left_reg - 8'd1;
            set_active_next     = !closing;
        end
        else if (open_set)
        begin
            set_active_next     = 1'b1;
            set_deleted_next    = item.entry_type == TYPE_FILE_DEL;
            slots_left_next     = item.byte_one;
            stream_pending_next = 1'b1;
            stream_match_next   = 1'b0;
            set_is_dir_next     = item.attributes[ATTR_DIR_BIT];
            saved_cluster_next  = '0;
            saved_length_next   = '0;
            saved_contig_next   = 1'b0;
            name_tally_next     = '0;
        end

        // directory boundary drops an open set and clears the end and bitmap stop flags
        if (item.last_in_dir)
        begin
            set_active_next     = 1'b0;
            slots_left_next     = '0;
            stream_pending_next = 1'b0;
            stream_match_next   = 1'b0;
            dir_ended_next      = 1'b0;
            bitmap_stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_active_reg     <= 1'b0;
            set_deleted_reg    <= 1'b0;
            slots_left_reg     <= '0;
            stream_pending_reg <= 1'b0;
            stream_match_reg   <= 1'b0;
            set_is_dir_reg     <= 1'b0;
            saved_cluster_reg  <= '0;
            saved_length_reg   <= '0;
            saved_contig_reg   <= 1'b0;
            name_tally_reg     <= '0;
            dir_ended_reg      <= 1'b0;
            bitmap_stopped_reg <= 1'b0;
        end
        else if (adv)
        begin
            set_active_reg     <= set_active_next;
            set_deleted_reg    <= set_deleted_next;
            slots_left_reg     <= slots_left_next;
            stream_pending_reg <= stream_pending_next;
            stream_match_reg   <= stream_match_next;
            set_is_dir_reg     <= set_is_dir_next;
            saved_cluster_reg  <= saved_cluster_next;
            saved_length_reg   <= saved_length_next;
            saved_contig_reg   <= saved_contig_next;
            name_tally_reg     <= name_tally_next;
            dir_ended_reg      <= dir_ended_next;
            bitmap_stopped_reg <= bitmap_stopped_next;
        end
    end

    `ESP_ASSERT_ALWAYS(a_tally_capped, name_tally_reg <= MaxNames, "name tally above cap")
    `ESP_ASSERT_NEXT(a_close_ends_set, adv && closing, !set_active_reg, "set still open after last secondary")
    `ESP_ASSERT_NEXT(a_end_stops_bitmap, adv && live && is_end && !item.last_in_dir, bitmap_stopped_reg, "bitmap reporting not stopped by end entry")
    `ESP_ASSERT_IMP(a_active_has_slots, set_active_reg, slots_left_reg != 8'd0, "open set with no slots left")

endmodule

`default_nettype wire

FILE: design/exfat_esp_rqueue.sv
// ----------------------------------------------------------------------------
// exfat_esp_rqueue
// result queue taking up to two results per cycle, one beat out per cycle while popped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "exfat_entry_set_parser_defines.svh"

module exfat_esp_rqueue (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [1:0]                           push_count,
    input  wire exfat_esp_pkg::result_t               push_a,
    input  wire exfat_esp_pkg::result_t               push_b,
    input  wire logic                                 pop,
    output exfat_esp_pkg::result_t                    head,
    output logic                                      head_valid,
    output logic [exfat_esp_pkg::RQ_LVL_W-1:0]        level
);
    import exfat_esp_pkg::*;

    result_t                entries [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [RQ_LVL_W-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
        count_next  = count_reg + RQ_LVL_W'(push_count) - RQ_LVL_W'(pop);
        head        = entries[rd_ptr_reg];
        head_valid  = count_reg != '0;
        level       = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entries[wr_ptr_reg] <= push_a;
        end
        if (push_count == 2'd2)
        begin
            entries[wr_ptr_reg + RQ_PTR_W'(1)] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ESP_ASSERT_ALWAYS(a_no_overflow, count_reg <= RQ_LVL_W'(RQ_DEPTH), "result queue overflow")
    `ESP_ASSERT_IMP(a_room_for_push, push_count != 2'd0, ({1'b0, count_reg} + {{RQ_LVL_W-1{1'b0}}, push_count}) <= (RQ_LVL_W + 1)'(RQ_DEPTH), "push into full queue")
    `ESP_ASSERT_IMP(a_pop_when_valid, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

FILE: design/exfat_entry_set_parser.sv
// ----------------------------------------------------------------------------
// exfat_entry_set_parser
// exFAT directory entry set parser: deleted files, subdirectories, bitmap
// ----------------------------------------------------------------------------
// One directory entry is taken per clock while s_tready is high. A beat
// goes into an input register, is parsed there against the set state, and
// its results (none, one, or a bitmap result followed by a set result) land
// in a four-entry result queue whose head drives the master side. The first
// result passes through the input register and then the result queue before
// it is offered on the master side. Entries flow at one per cycle as long as
// the master side drains; an entry giving two results needs two output
// beats, and input is held whenever the queue has fewer than two free
// slots. Configuration is accepted every cycle and should be written while
// idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module exfat_entry_set_parser #(
    parameter int unsigned MAX_NAME_ENTRIES = exfat_esp_pkg::MAX_NAME_ENTRIES_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    // entry_type, byte_one, attributes, entry_first_cluster, entry_data_length
    input  wire logic [exfat_esp_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire logic                                      s_tlast,   // last_in_dir
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // start_cluster, byte_length, contiguous, is_dir, names_found, cluster_ok,
    // clusters_needed
    output logic [exfat_esp_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic [exfat_esp_pkg::OUT_TUSER_W-1:0]          m_tuser,   // kind
    output logic                                           m_tlast,   // last_result
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic [exfat_esp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [exfat_esp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import exfat_esp_pkg::*;

    logic [31:0]         vol_clusters_reg;
    logic [4:0]          cluster_shift_reg;
    logic                report_bitmap_reg;
    cfg_t                cfg;

    logic                in_valid_reg;
    item_t               in_item_reg;
    logic                adv;
    logic                take;

    logic [1:0]          push_count;
    result_t             res_a;
    result_t             res_b;
    result_t             head;
    logic                head_valid;
    logic [RQ_LVL_W-1:0] level;
    logic                pop;

    // config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_clusters_reg  <= VOLUME_CLUSTERS_RST;
            cluster_shift_reg <= CLUSTER_SHIFT_RST;
            report_bitmap_reg <= REPORT_BITMAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_VOLUME_CLUSTERS: vol_clusters_reg  <= cfg_data;
                REG_CLUSTER_SHIFT:   cluster_shift_reg <= cfg_data[4:0];
                REG_REPORT_BITMAP:   report_bitmap_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    assign cfg.volume_clusters = vol_clusters_reg;
    assign cfg.cluster_shift   = cluster_shift_reg;
    assign cfg.report_bitmap   = report_bitmap_reg;

    // input register, drains when the queue has room for two results
    assign adv      = in_valid_reg && (level <= RQ_LVL_W'(RQ_DEPTH - 2));
    assign s_tready = !in_valid_reg || adv;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.entry_type          <= s_tdata[7:0];
            in_item_reg.byte_one            <= s_tdata[15:8];
            in_item_reg.attributes          <= s_tdata[31:16];
            in_item_reg.entry_first_cluster <= s_tdata[63:32];
            in_item_reg.entry_data_length   <= s_tdata[127:64];
            in_item_reg.last_in_dir         <= s_tlast;
        end
    end

    exfat_esp_core #(
        .MAX_NAME_ENTRIES (MAX_NAME_ENTRIES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item       (in_item_reg),
        .cfg        (cfg),
        .push_count (push_count),
        .res_a      (res_a),
        .res_b      (res_b)
    );

    assign pop = head_valid && m_tready;

    exfat_esp_rqueue u_rqueue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_a     (res_a),
        .push_b     (res_b),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .level      (level)
    );

    assign m_tvalid = head_valid;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last_result;
    assign m_tdata  = {head.clusters_needed, head.cluster_ok, head.names_found,
                       head.is_dir, head.contiguous, head.byte_length, head.start_cluster};

endmodule

`default_nettype wire

FILE: verif/exfat_entry_set_parser_chk.sv
// ----------------------------------------------------------------------------
// exfat_entry_set_parser_chk
// entry set parser checker: tracks set state, predicts results and compares
// ----------------------------------------------------------------------------
// Watches the configuration, entry and result channels. Every accepted entry
// is run through a local model of the parser: open entry sets, stream type
// match, name counting, end entries, directory boundaries and bitmap
// reporting. The results it produces are queued in order. Every result beat is
// compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exfat_entry_set_parser_chk #(
    parameter int unsigned MAX_NAMES = exfat_esp_pkg::MAX_NAME_ENTRIES_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [exfat_esp_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                      s_tlast,
    input  logic                                      s_tvalid,
    input  logic                                      s_tready,
    input  logic [exfat_esp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic [exfat_esp_pkg::OUT_TUSER_W-1:0]     m_tuser,
    input  logic                                      m_tlast,
    input  logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic                                      cfg_valid,
    input  logic                                      cfg_ready,
    input  logic [exfat_esp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [exfat_esp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                        fail_count,
    output int                                        pending,
    output int                                        deleted_seen,
    output int                                        subdir_seen,
    output int                                        bitmap_seen
);

    import exfat_esp_pkg::*;

    // register copy
    logic [31:0] vol_cfg;
    logic [4:0]  shift_cfg;
    logic        bitmap_en;

    // parser state
    logic               in_set;
    logic               set_del;
    logic [7:0]         slots_remaining;
    logic [7:0]         slot_pos;
    logic               stream_ok;
    logic               dir_attr;
    logic [31:0]        held_cluster;
    logic [63:0]        held_length;
    logic               held_contig;
    logic [NAMES_W-1:0] names_counted;
    logic               dir_done;
    logic               bitmap_off;

    result_t expected_results[$];
    item_t   entry_in;
    result_t seen_result;
    result_t want_result;

    function automatic result_t make_result(input logic [1:0]         kind,
                                            input logic [31:0]        cl,
                                            input logic [63:0]        len,
                                            input logic               contig,
                                            input logic               isdir,
                                            input logic [NAMES_W-1:0] names);
        result_t     r;
        logic [64:0] rounded;
        // ceiling divide by the cluster size, wide enough not to overflow
        rounded = ({1'b0, len} + ((65'd1 << shift_cfg) - 65'd1)) >> shift_cfg;
        r.kind            = kind;
        r.start_cluster   = cl;
        r.byte_length     = len;
        r.contiguous      = contig;
        r.is_dir          = isdir;
        r.names_found     = names;
        r.cluster_ok      = (cl >= 32'd2) && ((cl - 32'd2) < vol_cfg);
        r.clusters_needed = rounded[31:0];
        r.last_result     = 1'b0;
        return r;
    endfunction

    task automatic parse_entry(input item_t e);
        result_t made[$];
        logic    name_hit;
        if (!dir_done)
        begin
            if (!bitmap_off && bitmap_en && e.entry_type == TYPE_BITMAP &&
                e.entry_first_cluster >= 32'd2 && e.entry_data_length != 64'd0 &&
                e.entry_data_length < (64'd1 << BITMAP_LIMIT_LOG))
                made.push_back(make_result(KIND_BITMAP, e.entry_first_cluster,
                                           e.entry_data_length, 1'b1, 1'b0, '0));
            // an end entry stops bitmap reporting even inside a set
            if (e.entry_type == TYPE_END)
                bitmap_off = 1'b1;

            if (in_set)
            begin
                slot_pos = slot_pos + 8'd1;
                if (slot_pos == 8'd1)
                begin
                    stream_ok    = e.entry_type ==
                                   (set_del ? TYPE_STREAM_DEL : TYPE_STREAM_LIVE);
                    held_cluster = e.entry_first_cluster;
                    held_length  = e.entry_data_length;
                    held_contig  = e.byte_one[FLAG_CONTIG_BIT];
                end
                else
                begin
                    name_hit = e.entry_type == (set_del ? TYPE_NAME_DEL : TYPE_NAME_LIVE);
                    if (stream_ok && names_counted < MAX_NAMES && name_hit)
                        names_counted = names_counted + 1'b1;
                end
                slots_remaining = slots_remaining - 8'd1;
                if (slots_remaining == 8'd0)
                begin
                    in_set = 1'b0;
                    if (stream_ok)
                    begin
                        if (set_del)
                            made.push_back(make_result(KIND_DELETED, held_cluster,
                                held_length, held_contig, dir_attr, names_counted));
                        else if (dir_attr && held_cluster >= 32'd2)
                            made.push_back(make_result(KIND_SUBDIR, held_cluster,
                                held_length, held_contig, 1'b1, names_counted));
                    end
                end
            end
            else if (e.entry_type == TYPE_END)
            begin
                dir_done = 1'b1;
            end
            else if ((e.entry_type == TYPE_FILE_LIVE || e.entry_type == TYPE_FILE_DEL) &&
                     e.byte_one != 8'd0)
            begin
                in_set          = 1'b1;
                set_del         = e.entry_type == TYPE_FILE_DEL;
                slots_remaining = e.byte_one;
                slot_pos        = 8'd0;
                stream_ok       = 1'b0;
                dir_attr        = e.attributes[ATTR_DIR_BIT];
                held_cluster    = '0;
                held_length     = '0;
                held_contig     = 1'b0;
                names_counted   = '0;
            end
        end

        // directory boundary drops any open set and clears the end and bitmap stop flags
        if (e.last_in_dir)
        begin
            in_set          = 1'b0;
            slots_remaining = 8'd0;
            slot_pos        = 8'd0;
            stream_ok       = 1'b0;
            dir_done        = 1'b0;
            bitmap_off      = 1'b0;
        end

        if (made.size() > 0)
            made[made.size()-1].last_result = 1'b1;
        foreach (made[i])
            expected_results.push_back(made[i]);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_cfg         = VOLUME_CLUSTERS_RST;
            shift_cfg       = CLUSTER_SHIFT_RST;
            bitmap_en       = REPORT_BITMAP_RST;
            in_set          = 1'b0;
            set_del         = 1'b0;
            slots_remaining = 8'd0;
            slot_pos        = 8'd0;
            stream_ok       = 1'b0;
            dir_attr        = 1'b0;
            held_cluster    = '0;
            held_length     = '0;
            held_contig     = 1'b0;
            names_counted   = '0;
            dir_done        = 1'b0;
            bitmap_off      = 1'b0;
            expected_results.delete();
            fail_count      = 0;
            pending         = 0;
            deleted_seen    = 0;
            subdir_seen     = 0;
            bitmap_seen     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VOLUME_CLUSTERS: vol_cfg   = cfg_data;
                    REG_CLUSTER_SHIFT:   shift_cfg = cfg_data[4:0];
                    REG_REPORT_BITMAP:   bitmap_en = cfg_data[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                entry_in.entry_type          = s_tdata[7:0];
                entry_in.byte_one            = s_tdata[15:8];
                entry_in.attributes          = s_tdata[31:16];
                entry_in.entry_first_cluster = s_tdata[63:32];
                entry_in.entry_data_length   = s_tdata[127:64];
                entry_in.last_in_dir         = s_tlast;
                parse_entry(entry_in);
            end

            if (m_tvalid && m_tready)
            begin
                seen_result.kind            = m_tuser;
                seen_result.start_cluster   = m_tdata[31:0];
                seen_result.byte_length     = m_tdata[95:32];
                seen_result.contiguous      = m_tdata[96];
                seen_result.is_dir          = m_tdata[97];
                seen_result.names_found     = m_tdata[102:98];
                seen_result.cluster_ok      = m_tdata[103];
                seen_result.clusters_needed = m_tdata[135:104];
                seen_result.last_result     = m_tlast;
                case (seen_result.kind)
                    KIND_DELETED: deleted_seen++;
                    KIND_SUBDIR:  subdir_seen++;
                    KIND_BITMAP:  bitmap_seen++;
                    default: ;
                endcase
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: unexpected result beat, expected none, %s",
                             $time, "got one");
                    $display("%0t ns: unexpected beat kind %0d cl 0x%0h",
                             $time, seen_result.kind, seen_result.start_cluster);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    check_field("kind", 64'(want_result.kind), 64'(seen_result.kind));
                    check_field("start_cluster", 64'(want_result.start_cluster),
                                64'(seen_result.start_cluster));
                    check_field("byte_length", want_result.byte_length,
                                seen_result.byte_length);
                    check_field("contiguous", 64'(want_result.contiguous),
                                64'(seen_result.contiguous));
                    check_field("is_dir", 64'(want_result.is_dir),
                                64'(seen_result.is_dir));
                    check_field("names_found", 64'(want_result.names_found),
                                64'(seen_result.names_found));
                    check_field("cluster_ok", 64'(want_result.cluster_ok),
                                64'(seen_result.cluster_ok));
                    check_field("clusters_needed", 64'(want_result.clusters_needed),
                                64'(seen_result.clusters_needed));
                    check_field("last_result", 64'(want_result.last_result),
                                64'(seen_result.last_result));
                end
            end

            pending = expected_results.size();
        end
    end

endmodule

FILE: verif/exfat_entry_set_parser_tb.sv
// ----------------------------------------------------------------------------
// exfat_entry_set_parser_tb
// entry set parser testbench: directory entry stimulus and verdict
// ----------------------------------------------------------------------------
// Drives a short list of hand-built entry sets covering bitmap limits, stream
// mismatches, cut-off sets, end entries and double results, then random
// directories made mostly of well-formed entry sets with random content,
// mixed with bitmap entries, end entries and noise. Five register settings
// are run with per-setting idle and stall patterns. The checker beside the
// block predicts and compares results; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exfat_entry_set_parser_tb;

    import exfat_esp_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 10;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]     s_tdata;
    logic                      s_tlast;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [OUT_TDATA_W-1:0]    m_tdata;
    logic [OUT_TUSER_W-1:0]    m_tuser;
    logic                      m_tlast;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int deleted_seen;
    int subdir_seen;
    int bitmap_seen;

    int          entries_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] cur_vol = VOLUME_CLUSTERS_RST;

    logic [31:0] ph_vol [PHASES] = '{32'd1000, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFF5, 32'd0};
    logic [4:0]  ph_shift [PHASES] = '{5'd9, 5'd31, 5'd0, 5'd25, 5'd12};
    logic        ph_bitmap [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    int          ph_tx [PHASES] = '{0, 64, 0, 33, 0};
    int          ph_rx [PHASES] = '{0, 0, 64, 33, 0};

    exfat_entry_set_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    exfat_entry_set_parser_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .deleted_seen (deleted_seen),
        .subdir_seen  (subdir_seen),
        .bitmap_seen  (bitmap_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending);
                $display("exfat_entry_set_parser_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic item_t mk_entry(input logic [7:0]  etype,
                                       input logic [7:0]  b1,
                                       input logic [15:0] attr,
                                       input logic [31:0] cl,
                                       input logic [63:0] len,
                                       input logic        last);
        item_t e;
        e.entry_type          = etype;
        e.byte_one            = b1;
        e.attributes          = attr;
        e.entry_first_cluster = cl;
        e.entry_data_length   = len;
        e.last_in_dir         = last;
        return e;
    endfunction

    function automatic logic [31:0] pick_cluster();
        case ($urandom_range(7))
            0: return 32'($urandom_range(3));
            1: return cur_vol;
            2: return cur_vol + 32'd1;
            3: return cur_vol + 32'd2;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_length();
        int k;
        k = int'($urandom_range(63));
        case ($urandom_range(7))
            0: return 64'd0;
            1: return 64'($urandom_range(1, 4096));
            2: return 64'd1 << k;
            3: return (64'd1 << k) - 64'd1;
            4: return '1;
            // around the bitmap size limit
            5: return (64'd1 << BITMAP_LIMIT_LOG) - 64'($urandom_range(1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic rare_last();
        return $urandom_range(49) == 0;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_entry(input item_t e);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {e.entry_data_length, e.entry_first_cluster, e.attributes,
                     e.byte_one, e.entry_type};
        s_tlast  <= e.last_in_dir;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        entries_sent++;
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic apply_settings(input int p);
        logic [31:0] vol;
        logic [4:0]  shift;
        logic        bmp;
        vol   = ph_vol[p];
        shift = ph_shift[p];
        bmp   = ph_bitmap[p];
        if (p == PHASES - 1)
        begin
            vol   = $urandom;
            shift = 5'($urandom_range(31));
            bmp   = 1'($urandom_range(1));
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);
        cfg_write(REG_VOLUME_CLUSTERS, vol);
        cfg_write(REG_CLUSTER_SHIFT, {27'd0, shift});
        cfg_write(REG_REPORT_BITMAP, {31'd0, bmp});
        cfg_valid <= 1'b0;
        cur_vol   = vol;
        @(negedge clk);
    endtask

    task automatic send_directed();
        // bitmap entries at the cluster and length limits
        send_entry(mk_entry(TYPE_BITMAP, 8'h00, 16'h0000, 32'd2, 64'd1, 1'b0));
        send_entry(mk_entry(TYPE_BITMAP, 8'h00, 16'h0000, 32'd1, 64'd64, 1'b0));
        send_entry(mk_entry(TYPE_BITMAP, 8'h00, 16'h0000, 32'd3, 64'h800_0000, 1'b0));
        send_entry(mk_entry(TYPE_BITMAP, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                            64'h7FF_FFFF, 1'b0));
        // deleted file with two names
        send_entry(mk_entry(TYPE_FILE_DEL, 8'd3, 16'h0010, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_DEL, 8'h02, 16'h0000, 32'd5, 64'h1001, 1'b0));
        send_entry(mk_entry(TYPE_NAME_DEL, 8'h00, 16'h0000, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_NAME_DEL, 8'h00, 16'h0000, 32'd0, 64'd0, 1'b0));
        // live subdirectory with extreme cluster and length
        send_entry(mk_entry(TYPE_FILE_LIVE, 8'd2, 16'h0010, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_LIVE, 8'h00, 16'h0000, 32'hFFFF_FFFF, '1, 1'b0));
        send_entry(mk_entry(TYPE_NAME_LIVE, 8'h00, 16'h0000, 32'd0, 64'd0, 1'b0));
        // live plain file: no result
        send_entry(mk_entry(TYPE_FILE_LIVE, 8'd1, 16'h0000, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_LIVE, 8'hFF, 16'h0000, 32'd3, 64'd100, 1'b0));
        // deleted set with a live stream type
        send_entry(mk_entry(TYPE_FILE_DEL, 8'd2, 16'h0000, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_LIVE, 8'h02, 16'h0000, 32'd9, 64'd9, 1'b0));
        send_entry(mk_entry(TYPE_NAME_DEL, 8'h00, 16'h0000, 32'd0, 64'd0, 1'b0));
        // live directory whose cluster is below 2
        send_entry(mk_entry(TYPE_FILE_LIVE, 8'd1, 16'hFFFF, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_LIVE, 8'h02, 16'h0000, 32'd1, 64'd4096, 1'b0));
        // zero secondary count
        send_entry(mk_entry(TYPE_FILE_LIVE, 8'd0, 16'h0010, 32'd0, 64'd0, 1'b0));
        // last secondary is a bitmap: two results from one beat
        send_entry(mk_entry(TYPE_FILE_DEL, 8'd2, 16'h0000, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_DEL, 8'h00, 16'h0000, 32'd1000, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_BITMAP, 8'h00, 16'h0000, 32'd1001, 64'd10, 1'b0));
        // set cut off by the directory boundary
        send_entry(mk_entry(TYPE_FILE_DEL, 8'd3, 16'h0000, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_DEL, 8'h00, 16'h0000, 32'd7, 64'd7, 1'b1));
        // end entry closes a set and stops the bitmap
        send_entry(mk_entry(TYPE_FILE_LIVE, 8'd2, 16'h0010, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_LIVE, 8'h00, 16'h0000, 32'd7, 64'd512, 1'b0));
        send_entry(mk_entry(TYPE_END, 8'h00, 16'h0000, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_BITMAP, 8'h00, 16'h0000, 32'd2, 64'd1, 1'b0));
        // end entry outside a set, rest of the directory ignored
        send_entry(mk_entry(TYPE_END, 8'h00, 16'h0000, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_FILE_DEL, 8'd1, 16'h0000, 32'd0, 64'd0, 1'b0));
        send_entry(mk_entry(TYPE_STREAM_DEL, 8'h00, 16'h0000, 32'd4, 64'd4, 1'b1));
        send_entry(mk_entry(TYPE_BITMAP, 8'h00, 16'h0000, 32'd2, 64'd1, 1'b0));
    endtask

    task automatic send_burst();
        int          pick;
        int          r;
        int          cnt;
        logic        del;
        logic [7:0]  etype;
        pick = int'($urandom_range(99));
        if (pick < 55)
        begin
            del = 1'($urandom_range(1));
            r   = int'($urandom_range(99));
            if (r < 70)
                cnt = int'($urandom_range(1, 4));
            else if (r < 95)
                cnt = int'($urandom_range(5, 21));
            else if (r < 99)
                cnt = int'($urandom_range(22, 40));
            else
                cnt = int'($urandom_range(0, 255));
            send_entry(mk_entry(del ? TYPE_FILE_DEL : TYPE_FILE_LIVE, cnt[7:0],
                                16'($urandom), $urandom, pick_length(), rare_last()));
            for (int i = 1; i <= cnt; i++)
            begin
                if (i == 1)
                begin
                    if ($urandom_range(9) != 0)
                        etype = del ? TYPE_STREAM_DEL : TYPE_STREAM_LIVE;
                    else
                        etype = 8'($urandom);
                    send_entry(mk_entry(etype, 8'($urandom), 16'($urandom),
                                        pick_cluster(), pick_length(), rare_last()));
                end
                else
                begin
                    r = int'($urandom_range(99));
                    if (r < 80)
                        etype = del ? TYPE_NAME_DEL : TYPE_NAME_LIVE;
                    else if (r < 88)
                        etype = del ? TYPE_NAME_LIVE : TYPE_NAME_DEL;
                    else
                        etype = 8'($urandom);
                    send_entry(mk_entry(etype, 8'($urandom), 16'($urandom), $urandom,
                                        {$urandom, $urandom}, rare_last()));
                end
            end
        end
        else if (pick < 67)
        begin
            send_entry(mk_entry(TYPE_BITMAP, 8'($urandom), 16'($urandom), pick_cluster(),
                                pick_length(), rare_last()));
        end
        else if (pick < 72)
        begin
            // end entry, a few ignored slots, then the next directory
            send_entry(mk_entry(TYPE_END, 8'($urandom), 16'($urandom), $urandom,
                                {$urandom, $urandom}, 1'b0));
            cnt = int'($urandom_range(3));
            for (int i = 0; i < cnt; i++)
                send_entry(mk_entry(8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                                    {$urandom, $urandom}, 1'b0));
            send_entry(mk_entry(8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                                {$urandom, $urandom}, 1'b1));
        end
        else
        begin
            send_entry(mk_entry(8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                                {$urandom, $urandom}, $urandom_range(15) == 0));
        end
    endtask

    initial
    begin
        int target;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tvalid  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_VOLUME_CLUSTERS;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
            apply_settings(p);
            if (p == 0)
                send_directed();
            tx_idle_pct  = ph_tx[p];
            rx_stall_pct = ph_rx[p];

            // long result-side hold-off while entries keep coming
            if (p == 0 || p == 2)
            begin
                hold_request = 150;
                target = entries_sent + 40;
                while (entries_sent < target)
                    send_burst();
            end

            target = entries_sent + PHASE_ITEMS;
            while (entries_sent < target)
            begin
                send_burst();
                // pause mid-phase until everything has drained
                if (entries_sent >= target - PHASE_ITEMS / 2 && entries_sent < target - 100)
                begin
                    s_tvalid <= 1'b0;
                    wait (pending == 0);
                    @(negedge clk);
                end
            end
        end

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d entries over %0d register settings with idle, stall and hold-off",
                 entries_sent, PHASES);
        $display("results checked: %0d deleted file, %0d subdirectory, %0d bitmap, %0d failures",
                 deleted_seen, subdir_seen, bitmap_seen, fail_count);
        if (fail_count == 0)
            $display("exfat_entry_set_parser_tb: done, clean");
        else
            $display("exfat_entry_set_parser_tb: done, errors");
        $finish;
    end

endmodule
